@@ rtl/assert_macros.svh @@
// Assertion macros for the transform unit RTL.
// Included by obt_ctrl, the module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OBT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OBT_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OBT_ASSERT(lbl, clk, rst_n, prop, msg)
`define OBT_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/obt_pkg.sv @@
// Types and constants of the orbital basis transform unit.
// No dependencies; used by every module of the block.
package obt_pkg;

    localparam logic [1:0] ACT_LOAD_V = 2'd0;
    localparam logic [1:0] ACT_LOAD_C = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_BAD = 2'd1;
    localparam logic [1:0] STATUS_SAT = 2'd2;

    localparam logic [1:0] CFG_BASIS_COUNT = 2'd0;
    localparam logic [1:0] CFG_OCC_COUNT   = 2'd1;
    localparam logic [1:0] CFG_VIRT_COUNT  = 2'd2;

    localparam int FRAC_BITS = 24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [31:0] value_real;
        logic signed [31:0] value_imag;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         occ_out;
        logic [5:0]         virt_out;
        logic signed [63:0] sum_real;
        logic signed [63:0] sum_imag;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic       load_v;
        logic       load_c;
        logic       start;
        logic       set_bad;
        logic       issue;
        logic       last;
        logic       publish;
        logic [6:0] vrow;
        logic [6:0] nu;
        logic [6:0] mu;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_status;

endpackage

@@ rtl/obt_ctrl.sv @@
// Controller of the transform unit: config registers, handshakes, term sequencer.
// Depends on obt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module obt_ctrl #(
    parameter int MAX_BASIS = 64,
    parameter int MAX_BANDS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  obt_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [6:0]          i_cfg_data,
    output obt_pkg::t_dp_cmd    o_cmd,
    input  obt_pkg::t_dp_status i_status
);
    import obt_pkg::*;

    t_state     r_state, n_state;
    logic [6:0] r_basis_count;
    logic [5:0] r_occ_count;
    logic [5:0] r_virt_count;
    logic [6:0] r_nu, r_mu;
    logic       r_out_valid;
    logic       accept;
    logic       bad;
    logic [6:0] bc_last;
    logic       mu_end;
    t_dp_cmd    cmd;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
    assign accept      = i_in_valid && o_in_ready;
    assign bc_last     = 7'(r_basis_count - 7'd1);
    assign mu_end      = (r_mu == bc_last);

    always_comb begin
        bad = (r_basis_count == 7'd0) || (int'(r_basis_count) > MAX_BASIS) ||
              (i_in_item.row_index >= r_occ_count) ||
              (i_in_item.col_index >= r_virt_count) ||
              ((int'(r_occ_count) + int'(i_in_item.col_index)) >= MAX_BANDS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis_count <= 7'd64;
            r_occ_count   <= 6'd1;
            r_virt_count  <= 6'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASIS_COUNT: r_basis_count <= i_cfg_data;
                CFG_OCC_COUNT:   r_occ_count   <= i_cfg_data[5:0];
                CFG_VIRT_COUNT:  r_virt_count  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_nu        <= '0;
            r_mu        <= '0;
        end else begin
            r_state <= n_state;
            if (cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cmd.start) begin
                r_nu <= '0;
                r_mu <= '0;
            end else if (cmd.issue) begin
                if (mu_end) begin
                    r_mu <= '0;
                    r_nu <= 7'(r_nu + 7'd1);
                end else begin
                    r_mu <= 7'(r_mu + 7'd1);
                end
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        cmd.nu   = r_nu;
        cmd.mu   = r_mu;
        cmd.vrow = 7'({1'b0, r_occ_count} + {1'b0, i_in_item.col_index});
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in_item.action)
                        ACT_LOAD_V: cmd.load_v = 1'b1;
                        ACT_LOAD_C: cmd.load_c = 1'b1;
                        ACT_QUERY: begin
                            if (bad) begin
                                cmd.set_bad = 1'b1;
                                n_state     = ST_HOLD;
                            end else begin
                                cmd.start = 1'b1;
                                n_state   = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                cmd.last  = mu_end && (r_nu == bc_last);
                if (cmd.last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_status.done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // hand over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    cmd.publish = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `OBT_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (r_state == ST_IDLE), "not idle after reset")
    `OBT_ASSERT(a_done_flush, i_clk, i_rst_n, i_status.done |-> (r_state == ST_FLUSH), "done outside flush")
    `OBT_ASSERT(a_mu_range, i_clk, i_rst_n, (r_state == ST_RUN) |-> (r_mu < r_basis_count && r_nu < r_basis_count), "term counter out of range")
    `OBT_ASSERT(a_pub_once, i_clk, i_rst_n, cmd.publish |=> (r_out_valid && r_state == ST_IDLE), "publish lost")

endmodule

@@ rtl/obt_datapath.sv @@
// Datapath: V and C memories, pipelined complex product chain, saturating accumulator.
// Depends on obt_pkg; driven by obt_ctrl commands.
module obt_datapath #(
    parameter int MAX_BASIS = 64,
    parameter int MAX_BANDS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  obt_pkg::t_in_item   i_in_item,
    input  obt_pkg::t_dp_cmd    i_cmd,
    output obt_pkg::t_dp_status o_status,
    output obt_pkg::t_out_item  o_out_item
);
    import obt_pkg::*;

    localparam int VDEPTH = MAX_BASIS * MAX_BASIS;
    localparam int CDEPTH = MAX_BANDS * MAX_BASIS;
    localparam int VAW    = $clog2(VDEPTH);
    localparam int CAW    = $clog2(CDEPTH);

    logic [63:0] mem_v [VDEPTH];
    logic [63:0] mem_c [CDEPTH];

    logic [5:0] r_row_i, r_virt_a;
    logic [6:0] r_vrow;

    logic [VAW-1:0] v_waddr, v_raddr;
    logic [CAW-1:0] c_waddr, ca_raddr, ci_raddr;
    logic           v_wok, c_wok;

    // stage 1: memory read data
    logic        r_vld1, r_lst1;
    logic [63:0] r_v, r_ca, r_ci;
    // stage 2: first products
    logic               r_vld2, r_lst2;
    logic signed [63:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [31:0] r_car2, r_cai2;
    // stage 3: t = V * C[i]
    logic               r_vld3, r_lst3;
    logic signed [40:0] r_tr, r_ti;
    logic signed [31:0] r_car3, r_cai3;
    // stage 4: split products
    logic               r_vld4, r_lst4;
    logic signed [48:0] r_h_rr, r_h_ii, r_h_ri, r_h_ir;
    logic signed [56:0] r_l_rr, r_l_ii, r_l_ri, r_l_ir;
    // stage 5: rounded products
    logic               r_vld5, r_lst5;
    logic signed [49:0] r_m_rr, r_m_ii, r_m_ri, r_m_ir;
    // stage 6: terms
    logic               r_vld6, r_lst6;
    logic signed [50:0] r_term_re, r_term_im;
    // accumulator
    logic signed [63:0] r_acc_re, r_acc_im;
    logic               r_sat, r_bad, r_done;
    t_out_item          r_out;

    logic signed [63:0] rnd_rr, rnd_ri, rnd_ii, rnd_ir;
    logic signed [16:0] hi_r, hi_i;
    logic signed [24:0] lo_r, lo_i;
    logic signed [56:0] lr_rr, lr_ii, lr_ri, lr_ir;
    logic signed [64:0] sum_re, sum_im;
    logic               ovf_re, ovf_im;

    assign v_wok   = (int'(i_in_item.row_index) < MAX_BASIS) &&
                     (int'(i_in_item.col_index) < MAX_BASIS);
    assign c_wok   = (int'(i_in_item.row_index) < MAX_BANDS) &&
                     (int'(i_in_item.col_index) < MAX_BASIS);
    assign v_waddr = VAW'(int'(i_in_item.row_index) * MAX_BASIS + int'(i_in_item.col_index));
    assign c_waddr = CAW'(int'(i_in_item.row_index) * MAX_BASIS + int'(i_in_item.col_index));
    assign v_raddr  = VAW'(int'(i_cmd.nu) * MAX_BASIS + int'(i_cmd.mu));
    assign ca_raddr = CAW'(int'(r_vrow) * MAX_BASIS + int'(i_cmd.mu));
    assign ci_raddr = CAW'(int'(r_row_i) * MAX_BASIS + int'(i_cmd.nu));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_v && v_wok) begin
            mem_v[v_waddr] <= {i_in_item.value_imag, i_in_item.value_real};
        end
        r_v <= mem_v[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_c && c_wok) begin
            mem_c[c_waddr] <= {i_in_item.value_imag, i_in_item.value_real};
        end
        r_ca <= mem_c[ca_raddr];
        r_ci <= mem_c[ci_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vld1 <= i_cmd.issue;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
            r_done <= r_vld6 && r_lst6;
        end
    end

    always_comb begin
        rnd_rr = r_p_rr + (64'sd1 <<< (FRAC_BITS - 1));
        rnd_ii = r_p_ii + (64'sd1 <<< (FRAC_BITS - 1));
        rnd_ri = r_p_ri + (64'sd1 <<< (FRAC_BITS - 1));
        rnd_ir = r_p_ir + (64'sd1 <<< (FRAC_BITS - 1));
        hi_r   = r_tr[40:24];
        hi_i   = r_ti[40:24];
        lo_r   = $signed({1'b0, r_tr[23:0]});
        lo_i   = $signed({1'b0, r_ti[23:0]});
        lr_rr  = r_l_rr + (57'sd1 <<< (FRAC_BITS - 1));
        lr_ii  = r_l_ii + (57'sd1 <<< (FRAC_BITS - 1));
        lr_ri  = r_l_ri + (57'sd1 <<< (FRAC_BITS - 1));
        lr_ir  = r_l_ir + (57'sd1 <<< (FRAC_BITS - 1));
        sum_re = 65'(r_acc_re) + 65'(r_term_re);
        sum_im = 65'(r_acc_im) + 65'(r_term_im);
        ovf_re = sum_re[64] != sum_re[63];
        ovf_im = sum_im[64] != sum_im[63];
    end

    always_ff @(posedge i_clk) begin
        r_lst1 <= i_cmd.last;
        r_lst2 <= r_lst1;
        r_lst3 <= r_lst2;
        r_lst4 <= r_lst3;
        r_lst5 <= r_lst4;
        r_lst6 <= r_lst5;

        r_p_rr <= 64'($signed(r_v[31:0]))  * 64'($signed(r_ci[31:0]));
        r_p_ii <= 64'($signed(r_v[63:32])) * 64'($signed(r_ci[63:32]));
        r_p_ri <= 64'($signed(r_v[31:0]))  * 64'($signed(r_ci[63:32]));
        r_p_ir <= 64'($signed(r_v[63:32])) * 64'($signed(r_ci[31:0]));
        r_car2 <= $signed(r_ca[31:0]);
        r_cai2 <= $signed(r_ca[63:32]);

        r_tr   <= 41'($signed(rnd_rr[63:24])) - 41'($signed(rnd_ii[63:24]));
        r_ti   <= 41'($signed(rnd_ri[63:24])) + 41'($signed(rnd_ir[63:24]));
        r_car3 <= r_car2;
        r_cai3 <= r_cai2;

        // term_re = car*tr + cai*ti, term_im = car*ti - cai*tr
        r_h_rr <= 49'(r_car3) * 49'(hi_r);
        r_l_rr <= 57'(r_car3) * 57'(lo_r);
        r_h_ii <= 49'(r_cai3) * 49'(hi_i);
        r_l_ii <= 57'(r_cai3) * 57'(lo_i);
        r_h_ri <= 49'(r_car3) * 49'(hi_i);
        r_l_ri <= 57'(r_car3) * 57'(lo_i);
        r_h_ir <= 49'(r_cai3) * 49'(hi_r);
        r_l_ir <= 57'(r_cai3) * 57'(lo_r);

        r_m_rr <= 50'(r_h_rr) + 50'($signed(lr_rr[56:24]));
        r_m_ii <= 50'(r_h_ii) + 50'($signed(lr_ii[56:24]));
        r_m_ri <= 50'(r_h_ri) + 50'($signed(lr_ri[56:24]));
        r_m_ir <= 50'(r_h_ir) + 50'($signed(lr_ir[56:24]));

        r_term_re <= 51'(r_m_rr) + 51'(r_m_ii);
        r_term_im <= 51'(r_m_ri) - 51'(r_m_ir);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start || i_cmd.set_bad) begin
            r_row_i  <= i_in_item.row_index;
            r_virt_a <= i_in_item.col_index;
            r_vrow   <= i_cmd.vrow;
            r_acc_re <= '0;
            r_acc_im <= '0;
            r_sat    <= 1'b0;
            r_bad    <= i_cmd.set_bad;
        end else if (r_vld6) begin
            // clamp toward the sign of the true sum, keep the flag sticky
            r_acc_re <= ovf_re ? (sum_re[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                               : sum_re[63:0];
            r_acc_im <= ovf_im ? (sum_im[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                               : sum_im[63:0];
            r_sat    <= r_sat || ovf_re || ovf_im;
        end
        if (i_cmd.publish) begin
            r_out.occ_out  <= r_row_i;
            r_out.virt_out <= r_virt_a;
            r_out.sum_real <= r_acc_re;
            r_out.sum_imag <= r_acc_im;
            r_out.status   <= r_bad ? STATUS_BAD : (r_sat ? STATUS_SAT : STATUS_OK);
        end
    end

    assign o_status.done = r_done;
    assign o_out_item    = r_out;

endmodule

@@ rtl/orbital_basis_transform_unit.sv @@
// Top level of the orbital basis transform unit.
// Depends on obt_pkg, obt_ctrl and obt_datapath.

// A query streams one complex multiply-accumulate per cycle through the datapath
// pipeline and issues basis_count * basis_count terms, 4096 at the default
// basis_count of 64. The single read port of the V memory sets that rate. A query
// with bad indices or a bad basis count skips the pipeline and returns status 1.
// Inputs are taken only between queries; a finished result waits in the output
// register while the next request runs.
module orbital_basis_transform_unit #(
    parameter int MAX_BASIS = 64,
    parameter int MAX_BANDS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  obt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output obt_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data
);
    import obt_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    obt_ctrl #(
        .MAX_BASIS (MAX_BASIS),
        .MAX_BANDS (MAX_BANDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    obt_datapath #(
        .MAX_BASIS (MAX_BASIS),
        .MAX_BANDS (MAX_BANDS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule
